### src/ary_pkg.sv
// ary_pkg: shared constants, register indexes and control types for the
// alpha-scaled RGB to YUV 4:2:0 converter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ary_pkg;

    // frame size limits (defaults for the top-level parameters)
    localparam int ARY_MAX_WIDTH  = 4096;
    localparam int ARY_MAX_HEIGHT = 4096;

    // field and register widths
    localparam int CHAN_W     = 8;
    localparam int ALPHA_W    = 9;
    localparam int CFG_SIZE_W = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int PAIR_W     = 2 * (CHAN_W + 1);

    // size compares run at this width, enough for parameters up to 16384
    localparam int EXT_W = 15;

    // weighted sum and scaled sum widths
    localparam int WS_W = 25;
    localparam int T_W  = 36;

    // register reset values
    localparam logic [ALPHA_W-1:0]    ALPHA_RST  = 9'd256;
    localparam logic [CFG_SIZE_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [CFG_SIZE_W-1:0] HEIGHT_RST = 13'd480;

    // bt.601 studio-range coefficients, q0.16
    localparam logic signed [WS_W-1:0] K_YR = 25'sd16829;
    localparam logic signed [WS_W-1:0] K_YG = 25'sd33039;
    localparam logic signed [WS_W-1:0] K_YB = 25'sd6416;
    localparam logic signed [WS_W-1:0] K_UR = 25'sd9714;
    localparam logic signed [WS_W-1:0] K_UG = 25'sd19071;
    localparam logic signed [WS_W-1:0] K_UB = 25'sd28784;
    localparam logic signed [WS_W-1:0] K_VR = 25'sd28784;
    localparam logic signed [WS_W-1:0] K_VG = 25'sd24103;
    localparam logic signed [WS_W-1:0] K_VB = 25'sd4681;

    // offsets after the 2^24 scale: 16 for luma, 128 plus one half for chroma
    localparam logic signed [T_W-1:0] OFF_Y = 36'sd268435456;
    localparam logic signed [T_W-1:0] OFF_C = 36'sd2155872256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA  = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic load_in;
        logic step_mult;
        logic step_scale;
        logic finish;
    } ary_cmd_t;

    typedef struct packed {
        logic out_stall;
    } ary_stat_t;

endpackage

`default_nettype wire

### src/ary_ctrl.sv
// ary_ctrl: sequencer for one pixel request at a time (capture, multiply,
// scale, finish). Depends on ary_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ary_ctrl
    import ary_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire ary_stat_t stat,
    output ary_cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MULT,
        ST_SCALE,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb begin
        cmd             = '0;
        state_next      = state_reg;
        cmd.load_in     = (state_reg == ST_IDLE) && s_valid && ready_reg;
        cmd.step_mult   = (state_reg == ST_MULT);
        cmd.step_scale  = (state_reg == ST_SCALE);
        cmd.finish      = (state_reg == ST_FINISH) && !stat.out_stall;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.load_in) begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT:   state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_FINISH;
            ST_FINISH: begin
                if (cmd.finish) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_ready = ready_reg;

endmodule

`default_nettype wire

### src/ary_datapath.sv
// ary_datapath: config registers, raster counters, color conversion stages,
// chroma pair line buffer and output register. Depends on ary_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ary_datapath
    import ary_pkg::*;
#(
    parameter int MAX_WIDTH  = ARY_MAX_WIDTH,
    parameter int MAX_HEIGHT = ARY_MAX_HEIGHT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic [CHAN_W-1:0]     s_red,
    input  wire logic [CHAN_W-1:0]     s_green,
    input  wire logic [CHAN_W-1:0]     s_blue,
    input  wire ary_cmd_t              cmd,
    output ary_stat_t                  stat,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [CHAN_W-1:0]          m_luma,
    output logic                       m_chroma_valid,
    output logic [CHAN_W-1:0]          m_chroma_u,
    output logic [CHAN_W-1:0]          m_chroma_v,
    output logic                       m_frame_end
);

    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int RW         = $clog2(MAX_HEIGHT);
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam logic [EXT_W-1:0] MAX_W_EXT = EXT_W'(MAX_WIDTH);
    localparam logic [EXT_W-1:0] MAX_H_EXT = EXT_W'(MAX_HEIGHT);
    localparam logic [EXT_W-1:0] ONE_EXT   = EXT_W'(1);

    // config registers
    logic [ALPHA_W-1:0]    alpha_reg;
    logic [CFG_SIZE_W-1:0] width_reg;
    logic [CFG_SIZE_W-1:0] height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg  <= ALPHA_RST;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ALPHA:  alpha_reg  <= cfg_wr_data[ALPHA_W-1:0];
                CFG_WIDTH:  width_reg  <= cfg_wr_data[CFG_SIZE_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_wr_data[CFG_SIZE_W-1:0];
                default:    ;
            endcase
        end
    end

    // effective frame size
    logic [EXT_W-1:0] width_ext, height_ext, w_eff, h_eff;

    assign width_ext  = {{(EXT_W-CFG_SIZE_W){1'b0}}, width_reg};
    assign height_ext = {{(EXT_W-CFG_SIZE_W){1'b0}}, height_reg};

    always_comb begin
        if (width_ext == '0) begin
            w_eff = ONE_EXT;
        end else if (width_ext > MAX_W_EXT) begin
            w_eff = MAX_W_EXT;
        end else begin
            w_eff = width_ext;
        end
        if (height_ext == '0) begin
            h_eff = ONE_EXT;
        end else if (height_ext > MAX_H_EXT) begin
            h_eff = MAX_H_EXT;
        end else begin
            h_eff = height_ext;
        end
    end

    // raster counters
    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [EXT_W-1:0] col_ext, row_ext, col_half;
    logic             col_last, row_last, fend_now;

    assign col_ext  = {{(EXT_W-CW){1'b0}}, col_reg};
    assign row_ext  = {{(EXT_W-RW){1'b0}}, row_reg};
    assign col_half = col_ext >> 1;
    assign col_last = (col_ext + ONE_EXT) >= w_eff;
    assign row_last = (row_ext + ONE_EXT) >= h_eff;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        fend_now = 1'b0;
        if (col_last) begin
            col_next = '0;
            if (row_last) begin
                row_next = '0;
                fend_now = 1'b1;
            end else begin
                row_next = row_reg + RW'(1);
            end
        end else begin
            col_next = col_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cmd.load_in) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // captured request
    logic [CHAN_W-1:0] red_reg, green_reg, blue_reg;
    logic              col_odd_reg, row_odd_reg, fend_reg;
    logic [AW-1:0]     addr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            red_reg     <= s_red;
            green_reg   <= s_green;
            blue_reg    <= s_blue;
            col_odd_reg <= col_reg[0];
            row_odd_reg <= row_reg[0];
            fend_reg    <= fend_now;
            addr_reg    <= col_half[AW-1:0];
        end
    end

    // weighted sums of the channels
    logic signed [WS_W-1:0] r_s, g_s, b_s;
    logic signed [WS_W-1:0] wy_reg, wu_reg, wv_reg;

    assign r_s = signed'({{(WS_W-CHAN_W){1'b0}}, red_reg});
    assign g_s = signed'({{(WS_W-CHAN_W){1'b0}}, green_reg});
    assign b_s = signed'({{(WS_W-CHAN_W){1'b0}}, blue_reg});

    always_ff @(posedge aclk) begin
        if (cmd.step_mult) begin
            wy_reg <= K_YR * r_s + K_YG * g_s + K_YB * b_s;
            wu_reg <= K_UB * b_s - K_UR * r_s - K_UG * g_s;
            wv_reg <= K_VR * r_s - K_VG * g_s - K_VB * b_s;
        end
    end

    // alpha scaling plus offsets
    logic signed [T_W-1:0] alpha_s, wy_s, wu_s, wv_s;
    logic signed [T_W-1:0] ty_reg, tu_reg, tv_reg;

    assign alpha_s = signed'({{(T_W-ALPHA_W){1'b0}}, alpha_reg});
    assign wy_s    = {{(T_W-WS_W){wy_reg[WS_W-1]}}, wy_reg};
    assign wu_s    = {{(T_W-WS_W){wu_reg[WS_W-1]}}, wu_reg};
    assign wv_s    = {{(T_W-WS_W){wv_reg[WS_W-1]}}, wv_reg};

    always_ff @(posedge aclk) begin
        if (cmd.step_scale) begin
            ty_reg <= wy_s * alpha_s + OFF_Y;
            tu_reg <= wu_s * alpha_s + OFF_C;
            tv_reg <= wv_s * alpha_s + OFF_C;
        end
    end

    function automatic logic [CHAN_W-1:0] sat_shift(input logic signed [T_W-1:0] t);
        logic [CHAN_W-1:0] res;
        if (t[T_W-1]) begin
            res = '0;
        end else if (|t[T_W-2:24+CHAN_W]) begin
            res = '1;
        end else begin
            res = t[24+CHAN_W-1:24];
        end
        return res;
    endfunction

    // pair sum line buffer
    logic [PAIR_W-1:0] line_mem [LINE_DEPTH];
    logic [PAIR_W-1:0] rd_data_reg;
    logic              mem_we;

    logic [CHAN_W-1:0]   y8, u8, v8;
    logic [2*CHAN_W-1:0] left_reg;
    logic [CHAN_W:0]     pu, pv, rd_u, rd_v;
    logic [CHAN_W+1:0]   sum_u, sum_v;
    logic                blk_done;

    assign y8       = sat_shift(ty_reg);
    assign u8       = sat_shift(tu_reg);
    assign v8       = sat_shift(tv_reg);
    assign pu       = {1'b0, left_reg[2*CHAN_W-1:CHAN_W]} + {1'b0, u8};
    assign pv       = {1'b0, left_reg[CHAN_W-1:0]} + {1'b0, v8};
    assign rd_u     = rd_data_reg[PAIR_W-1:CHAN_W+1];
    assign rd_v     = rd_data_reg[CHAN_W:0];
    assign sum_u    = {1'b0, rd_u} + {1'b0, pu};
    assign sum_v    = {1'b0, rd_v} + {1'b0, pv};
    assign blk_done = col_odd_reg && row_odd_reg;
    assign mem_we   = cmd.finish && col_odd_reg && !row_odd_reg;

    always_ff @(posedge aclk) begin
        if (cmd.step_mult) begin
            rd_data_reg <= line_mem[addr_reg];
        end
        if (mem_we) begin
            line_mem[addr_reg] <= {pu, pv};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
        end else if (cmd.finish && !col_odd_reg) begin
            left_reg <= {u8, v8};
        end
    end

    // output register
    logic              m_valid_reg;
    logic [CHAN_W-1:0] luma_reg, cu_reg, cv_reg;
    logic              cvalid_reg, fend_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            luma_reg     <= y8;
            cvalid_reg   <= blk_done;
            cu_reg       <= blk_done ? sum_u[CHAN_W+1:2] : '0;
            cv_reg       <= blk_done ? sum_v[CHAN_W+1:2] : '0;
            fend_out_reg <= fend_reg;
        end
    end

    assign stat.out_stall = m_valid_reg && !m_ready;
    assign m_valid        = m_valid_reg;
    assign m_luma         = luma_reg;
    assign m_chroma_valid = cvalid_reg;
    assign m_chroma_u     = cu_reg;
    assign m_chroma_v     = cv_reg;
    assign m_frame_end    = fend_out_reg;

endmodule

`default_nettype wire

### src/alpha_rgb_to_yuv420.sv
// alpha_rgb_to_yuv420: top level, joins the sequencer and the datapath.
// Depends on ary_pkg, ary_ctrl and ary_datapath.
//
//   port group   direction  handshake           content
//   s_*          in         s_valid / s_ready   red, green, blue of one pixel
//   m_*          out        m_valid / m_ready   luma, chroma pair, frame end
//   cfg_*        in         cfg_wr_en           alpha, frame width, frame height
//
// one pixel passes in turn through capture, weighted sums, alpha scaling, finish;
// the pixel rate is set by the sequencer holding one request at a time
// a finished pixel waits in the output register while the next is taken in
// finish stalls only when the output register is still full
// reset is synchronous and needs no clearing pass; the line buffer is not reset
`timescale 1ns / 1ps
`default_nettype none

module alpha_rgb_to_yuv420
    import ary_pkg::*;
#(
    parameter int MAX_WIDTH  = ARY_MAX_WIDTH,
    parameter int MAX_HEIGHT = ARY_MAX_HEIGHT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [CHAN_W-1:0]     s_red,
    input  wire logic [CHAN_W-1:0]     s_green,
    input  wire logic [CHAN_W-1:0]     s_blue,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [CHAN_W-1:0]          m_luma,
    output logic                       m_chroma_valid,
    output logic [CHAN_W-1:0]          m_chroma_u,
    output logic [CHAN_W-1:0]          m_chroma_v,
    output logic                       m_frame_end
);

    ary_cmd_t  cmd;
    ary_stat_t stat;

    ary_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ary_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_red          (s_red),
        .s_green        (s_green),
        .s_blue         (s_blue),
        .cmd            (cmd),
        .stat           (stat),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_luma         (m_luma),
        .m_chroma_valid (m_chroma_valid),
        .m_chroma_u     (m_chroma_u),
        .m_chroma_v     (m_chroma_v),
        .m_frame_end    (m_frame_end)
    );

endmodule

`default_nettype wire

### src/ary_checker.sv
// ary_checker: port-level checks of the converter, bound to the top level.
// Depends on ary_pkg and alpha_rgb_to_yuv420.
`timescale 1ns / 1ps
`default_nettype none

module ary_checker
    import ary_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [CHAN_W-1:0] m_luma,
    input wire logic              m_chroma_valid,
    input wire logic [CHAN_W-1:0] m_chroma_u,
    input wire logic [CHAN_W-1:0] m_chroma_v,
    input wire logic              m_frame_end
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_luma) && $stable(m_chroma_u)
            && $stable(m_chroma_v) && $stable(m_chroma_valid) && $stable(m_frame_end))
        else $error("result changed while stalled");

    // no chroma values without a completed block
    a_chroma_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_chroma_valid |-> m_chroma_u == '0 && m_chroma_v == '0)
        else $error("chroma nonzero without chroma_valid");

    // one request in flight
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    // each request leads to a pending result after the multiply, scale and finish states
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> ##4 m_valid)
        else $error("no result after request");

endmodule

bind alpha_rgb_to_yuv420 ary_checker u_ary_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_luma         (m_luma),
    .m_chroma_valid (m_chroma_valid),
    .m_chroma_u     (m_chroma_u),
    .m_chroma_v     (m_chroma_v),
    .m_frame_end    (m_frame_end)
);

`default_nettype wire

### tb/alpha_rgb_to_yuv420_check.sv
// alpha_rgb_to_yuv420_check: watches the register port and both streams of the converter,
// predicts luma, averaged chroma and frame end for every pixel request, and compares
// them in order with the results. Depends on ary_pkg.
`timescale 1ns / 1ps

module alpha_rgb_to_yuv420_check
    import ary_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire logic [CHAN_W-1:0]     s_red,
    input  wire logic [CHAN_W-1:0]     s_green,
    input  wire logic [CHAN_W-1:0]     s_blue,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire logic [CHAN_W-1:0]     m_luma,
    input  wire logic                  m_chroma_valid,
    input  wire logic [CHAN_W-1:0]     m_chroma_u,
    input  wire logic [CHAN_W-1:0]     m_chroma_v,
    input  wire logic                  m_frame_end,
    output int                         fail_count,
    output int                         pending
);

    typedef struct packed {
        logic [CHAN_W-1:0] luma;
        logic              chroma_valid;
        logic [CHAN_W-1:0] chroma_u;
        logic [CHAN_W-1:0] chroma_v;
        logic              frame_end;
    } yuv_out_t;

    localparam int LINE_PAIRS = (ARY_MAX_WIDTH + 1) / 2;

    // bt.601 weights in q0.16
    localparam longint Y_R = 16829;
    localparam longint Y_G = 33039;
    localparam longint Y_B = 6416;
    localparam longint U_R = -9714;
    localparam longint U_G = -19071;
    localparam longint U_B = 28784;
    localparam longint V_R = 28784;
    localparam longint V_G = -24103;
    localparam longint V_B = -4681;

    logic [ALPHA_W-1:0]    alpha_q;
    logic [CFG_SIZE_W-1:0] width_q;
    logic [CFG_SIZE_W-1:0] height_q;
    int unsigned           col_pos;
    int unsigned           row_pos;
    logic [15:0]           left_uv;
    logic [PAIR_W-1:0]     pair_line [LINE_PAIRS];
    yuv_out_t              expected_yuv [$];
    int                    errors = 0;

    function automatic logic [CHAN_W-1:0] clamp_byte(input longint t);
        longint q;
        if (t < 0) q = 0;
        else q = t >>> 24;
        if (q > 255) q = 255;
        return q[CHAN_W-1:0];
    endfunction

    function automatic int unsigned frame_extent(input logic [CFG_SIZE_W-1:0] v,
                                                 input int unsigned limit);
        if (v == 0) return 1;
        return (v > limit) ? limit : v;
    endfunction

    // converts one pixel and advances the raster position
    function automatic yuv_out_t convert_pixel(input logic [CHAN_W-1:0] r,
                                               input logic [CHAN_W-1:0] g,
                                               input logic [CHAN_W-1:0] b);
        longint            rr, gg, bb, a;
        logic [CHAN_W-1:0] y, u, v;
        logic [8:0]        pu, pv;
        logic [9:0]        sum_u, sum_v;
        int unsigned       w, h, idx;
        yuv_out_t          res;
        rr = r;
        gg = g;
        bb = b;
        a = alpha_q;
        w = frame_extent(width_q, ARY_MAX_WIDTH);
        h = frame_extent(height_q, ARY_MAX_HEIGHT);
        res = '0;
        y = clamp_byte(a * (Y_R * rr + Y_G * gg + Y_B * bb) + (longint'(16) << 24));
        u = clamp_byte(a * (U_R * rr + U_G * gg + U_B * bb) + (longint'(128) << 24)
                       + (longint'(1) << 23));
        v = clamp_byte(a * (V_R * rr + V_G * gg + V_B * bb) + (longint'(128) << 24)
                       + (longint'(1) << 23));
        res.luma = y;
        if (col_pos[0] == 1'b0) begin
            left_uv = {u, v};
        end else begin
            pu = left_uv[15:8] + u;
            pv = left_uv[7:0] + v;
            idx = col_pos >> 1;
            if (row_pos[0] == 1'b0) begin
                pair_line[idx] = {pu, pv};
            end else begin
                sum_u = pair_line[idx][PAIR_W-1:9] + pu;
                sum_v = pair_line[idx][8:0] + pv;
                res.chroma_valid = 1'b1;
                res.chroma_u = sum_u[9:2];
                res.chroma_v = sum_v[9:2];
            end
        end
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            if (row_pos + 1 >= h) begin
                row_pos = 0;
                res.frame_end = 1'b1;
            end else begin
                row_pos++;
            end
        end else begin
            col_pos++;
        end
        return res;
    endfunction

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            errors++;
            if (errors <= 100)
                $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge aclk) begin : watch
        yuv_out_t want;
        if (!aresetn) begin
            alpha_q = ALPHA_RST;
            width_q = WIDTH_RST;
            height_q = HEIGHT_RST;
            col_pos = 0;
            row_pos = 0;
            left_uv = '0;
            expected_yuv.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_ALPHA:  alpha_q = cfg_wr_data[ALPHA_W-1:0];
                    CFG_WIDTH:  width_q = cfg_wr_data[CFG_SIZE_W-1:0];
                    CFG_HEIGHT: height_q = cfg_wr_data[CFG_SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_yuv.push_back(convert_pixel(s_red, s_green, s_blue));
            if (m_valid && m_ready) begin
                if (expected_yuv.size() == 0) begin
                    errors++;
                    $display("%0t ns: result with no request pending, expected none,",
                             $time);
                    $display("    got luma %0d", m_luma);
                end else begin
                    want = expected_yuv.pop_front();
                    check_field("luma", want.luma, m_luma);
                    check_field("chroma_valid", want.chroma_valid, m_chroma_valid);
                    check_field("chroma_u", want.chroma_u, m_chroma_u);
                    check_field("chroma_v", want.chroma_v, m_chroma_v);
                    check_field("frame_end", want.frame_end, m_frame_end);
                end
            end
        end
        pending <= expected_yuv.size();
        fail_count <= errors;
    end

endmodule

### tb/alpha_rgb_to_yuv420_test.sv
// alpha_rgb_to_yuv420_test: clock, reset, pixel requests with bursts and gaps, a stalling
// result side, register writes between phases and the verdict.
// Depends on ary_pkg, alpha_rgb_to_yuv420 and alpha_rgb_to_yuv420_check.
`timescale 1ns / 1ps

module alpha_rgb_to_yuv420_test;
    import ary_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_PIXELS = 900;
    localparam int BIG_PIXELS = 64;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [CHAN_W-1:0]     s_red;
    logic [CHAN_W-1:0]     s_green;
    logic [CHAN_W-1:0]     s_blue;
    logic                  m_valid;
    logic                  m_ready;
    logic [CHAN_W-1:0]     m_luma;
    logic                  m_chroma_valid;
    logic [CHAN_W-1:0]     m_chroma_u;
    logic [CHAN_W-1:0]     m_chroma_v;
    logic                  m_frame_end;
    int                    fail_count;
    int                    pending;

    int cycle_count;
    int burst_left;
    int pixels_sent;
    int reg_writes;

    alpha_rgb_to_yuv420 dut (.*);

    alpha_rgb_to_yuv420_check checker_i (.*);

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results pending", cycle_count, pending);
            $display("alpha_rgb_to_yuv420_test NOT OK");
            $finish;
        end
    end

    function automatic logic [CHAN_W-1:0] pick_channel();
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return CHAN_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [ALPHA_W-1:0] pick_alpha();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 9'd256;
            2: return ALPHA_W'($urandom_range(257, 511));
            default: return ALPHA_W'($urandom_range(1, 255));
        endcase
    endfunction

    // one pixel request; keeps valid up within a burst, drops it for a gap after
    task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b);
        s_valid <= 1'b1;
        s_red <= r;
        s_green <= g;
        s_blue <= b;
        do @(posedge aclk); while (!s_ready);
        pixels_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 15);
        end
    endtask

    task automatic send_random(input int count);
        repeat (count) send_pixel(pick_channel(), pick_channel(), pick_channel());
    endtask

    // sender pauses until every result is back
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        reg_writes++;
    endtask

    // result side: own stall pattern plus a long hold-off now and then
    initial begin : result_side
        int since_hold;
        int seg_len;
        int seg_mode;
        m_ready = 1'b0;
        since_hold = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (since_hold >= 4000) begin
                m_ready <= 1'b0;
                repeat (250) @(posedge aclk);
                since_hold = 0;
            end
            seg_mode = $urandom_range(0, 2);
            seg_len = $urandom_range(1, 40);
            repeat (seg_len) begin
                case (seg_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= ($urandom_range(0, 7) == 0);
                endcase
                @(posedge aclk);
                since_hold++;
            end
        end
    end

    initial begin : stimulus
        int          w, h, area, total, split, rnd_sent;
        int unsigned big_w [3];
        int unsigned big_h [3];
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_ALPHA;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_red = '0;
        s_green = '0;
        s_blue = '0;
        burst_left = 0;
        pixels_sent = 0;
        reg_writes = 0;
        big_w = '{4096, 8191, 1};
        big_h = '{2, 1, 8191};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset sizes, then shrink the width in the middle of an even row
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'h00);
        settle();
        write_reg(CFG_WIDTH, 13'd2);
        write_reg(CFG_HEIGHT, 13'd2);
        send_pixel(8'h00, 8'h00, 8'hFF);
        send_pixel(8'hFF, 8'hFF, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'hFF);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        settle();

        // alpha above 256 saturates high and low, alpha zero
        write_reg(CFG_ALPHA, 13'd511);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'hFF, 8'h00, 8'h00);
        send_pixel(8'h00, 8'h00, 8'hFF);
        settle();
        write_reg(CFG_ALPHA, 13'd0);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 8'h00, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'h00);
        settle();

        // odd width and height, then zero sizes taken as one
        write_reg(CFG_ALPHA, 13'd256);
        write_reg(CFG_WIDTH, 13'd3);
        write_reg(CFG_HEIGHT, 13'd3);
        send_random(9);
        settle();
        write_reg(CFG_WIDTH, 13'd0);
        write_reg(CFG_HEIGHT, 13'd0);
        send_random(2);
        settle();

        // height cut below the current row mid-frame
        write_reg(CFG_WIDTH, 13'd2);
        write_reg(CFG_HEIGHT, 13'd4);
        send_random(7);
        settle();
        write_reg(CFG_HEIGHT, 13'd2);
        send_random(1);
        settle();

        // width grown in the middle of an even row
        send_random(1);
        settle();
        write_reg(CFG_WIDTH, 13'd4);
        send_random(7);
        settle();

        // random small frames, alpha sometimes changed mid-frame
        rnd_sent = 0;
        while (rnd_sent < RANDOM_PIXELS) begin
            w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
            h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
            area = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
            total = area * $urandom_range(1, 3);
            split = (total > 1 && $urandom_range(0, 2) == 0) ? $urandom_range(1, total - 1) : -1;
            write_reg(CFG_WIDTH, CFG_DATA_W'(w));
            write_reg(CFG_HEIGHT, CFG_DATA_W'(h));
            write_reg(CFG_ALPHA, CFG_DATA_W'(pick_alpha()));
            for (int k = 0; k < total; k++) begin
                if (k == split) begin
                    settle();
                    write_reg(CFG_ALPHA, CFG_DATA_W'(pick_alpha()));
                end
                send_pixel(pick_channel(), pick_channel(), pick_channel());
            end
            rnd_sent += total;
            settle();
        end

        // wide and tall frames, width and height beyond the limit
        for (int i = 0; i < 3; i++) begin
            write_reg(CFG_WIDTH, CFG_DATA_W'(big_w[i]));
            write_reg(CFG_HEIGHT, CFG_DATA_W'(big_h[i]));
            write_reg(CFG_ALPHA, CFG_DATA_W'(pick_alpha()));
            send_random(BIG_PIXELS);
            settle();
        end

        repeat (20) @(posedge aclk);
        $display("run covered %0d pixel requests and %0d register writes:", pixels_sent, reg_writes);
        $display("frames from 1x1 to 12x8, odd sizes, mid-frame resizes, oversize limits, alpha 0..511");
        if (fail_count == 0) begin
            $display("alpha_rgb_to_yuv420_test OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("alpha_rgb_to_yuv420_test NOT OK");
        end
        $finish;
    end

endmodule
